FILE: sv/tccos_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tccos_pkg
// Shared types and constants of the ternary centred cosine core.
// ----------------------------------------------------------------------------
package tccos_pkg;

  // trit codes
  localparam logic [1:0] TRIT_NEG  = 2'd0;
  localparam logic [1:0] TRIT_POS  = 2'd2;

  localparam int unsigned MAG_W    = 16;
  localparam int unsigned BIT_W    = 4;
  localparam int unsigned ODD_W    = MAG_W + 1;
  localparam int unsigned ODD_SQ_W = 2 * ODD_W;
  localparam int unsigned FRAC_W   = 32;

  localparam logic signed [15:0] Q15_MAX = 16'sh7FFF;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_SQR  = 4'b0010,
    ST_MUL  = 4'b0100,
    ST_DONE = 4'b1000
  } back_state_t;

  function automatic logic trit_is_nonzero(input logic [1:0] code);
    return (code == TRIT_NEG) || (code == TRIT_POS);
  endfunction

endpackage

FILE: sv/tccos_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tccos_queue
// Two-entry queue of finished sums between the accumulator and the divider.
// ----------------------------------------------------------------------------
module tccos_queue #(
  parameter int unsigned WIDTH = 25
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    wr,
  input  logic [WIDTH-1:0]        wr_data,
  input  logic                    rd,
  output logic [WIDTH-1:0]        rd_data,
  output tccos_pkg::queue_status_t status
);
  import tccos_pkg::*;

  logic [WIDTH-1:0] mem [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;
  logic             do_wr;
  logic             do_rd;

  assign status.full  = (count == 2'd2);
  assign status.empty = (count == 2'd0);
  assign do_wr        = wr && !status.full;
  assign do_rd        = rd && !status.empty;
  assign rd_data      = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_wr) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_rd) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({do_wr, do_rd})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: sv/tccos_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tccos_front
// Accumulates dot product and squared norms, one trit pair a cycle while
// accept is high, and hands the closed sums to the queue on the last pair.
// ----------------------------------------------------------------------------
module tccos_front #(
  parameter int unsigned MAX_LENGTH = 240,
  parameter int unsigned SUM_W      = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 accept,
  input  logic [1:0]           trit_a,
  input  logic [1:0]           trit_b,
  input  logic                 last_pair,
  output logic                 q_wr,
  output logic [3*SUM_W:0]     q_data
);
  import tccos_pkg::*;

  localparam logic signed [SUM_W:0] DOT_MAX  = (SUM_W+1)'(MAX_LENGTH);
  localparam logic signed [SUM_W:0] DOT_ONE  = (SUM_W+1)'(1);
  localparam logic [SUM_W-1:0]      NORM_MAX = SUM_W'(MAX_LENGTH);

  logic signed [SUM_W:0] dot_sum, dot_sum_next;
  logic [SUM_W-1:0]      norm_a_sum, norm_a_sum_next;
  logic [SUM_W-1:0]      norm_b_sum, norm_b_sum_next;
  logic                  a_nz, b_nz, prod_pos, prod_neg;

  always_comb begin
    a_nz     = trit_is_nonzero(trit_a);
    b_nz     = trit_is_nonzero(trit_b);
    prod_pos = a_nz && b_nz && (trit_a == trit_b);
    prod_neg = a_nz && b_nz && (trit_a != trit_b);

    dot_sum_next = dot_sum;
    if (prod_pos && dot_sum != DOT_MAX) begin
      dot_sum_next = dot_sum + DOT_ONE;
    end else if (prod_neg && dot_sum != -DOT_MAX) begin
      dot_sum_next = dot_sum - DOT_ONE;
    end

    norm_a_sum_next = norm_a_sum;
    if (a_nz && norm_a_sum != NORM_MAX) begin
      norm_a_sum_next = norm_a_sum + 1'b1;
    end
    norm_b_sum_next = norm_b_sum;
    if (b_nz && norm_b_sum != NORM_MAX) begin
      norm_b_sum_next = norm_b_sum + 1'b1;
    end
  end

  assign q_wr   = accept && last_pair;
  assign q_data = {dot_sum_next, norm_a_sum_next, norm_b_sum_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      dot_sum    <= '0;
      norm_a_sum <= '0;
      norm_b_sum <= '0;
    end else if (accept) begin
      if (last_pair) begin
        dot_sum    <= '0;
        norm_a_sum <= '0;
        norm_b_sum <= '0;
      end else begin
        dot_sum    <= dot_sum_next;
        norm_a_sum <= norm_a_sum_next;
        norm_b_sum <= norm_b_sum_next;
      end
    end
  end

endmodule

FILE: sv/tccos_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tccos_back
// Bit-serial search for round(32768*|dot|/sqrt(na*nb)), a square state and
// a compare state a bit, then sign, saturation and the result register.
// ----------------------------------------------------------------------------
module tccos_back #(
  parameter int unsigned SUM_W      = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic [3*SUM_W:0]   q_data,
  input  tccos_pkg::queue_status_t q_status,
  output logic               q_rd,
  input  logic               pop,
  output logic               empty,
  output logic signed [15:0] similarity,
  output logic               zero_norm
);
  import tccos_pkg::*;

  localparam int unsigned SQ_W   = 2 * SUM_W;
  localparam int unsigned PROD_W = ODD_SQ_W + SQ_W;

  back_state_t           state;
  logic signed [SUM_W:0] in_dot;
  logic [SUM_W-1:0]      in_na, in_nb, in_mag;
  logic                  dot_neg, zn, out_valid;
  logic [SQ_W-1:0]       d_sq, p;
  logic [MAG_W-1:0]      m, cand;
  logic [BIT_W-1:0]      bitn;
  logic [ODD_W-1:0]      odd;
  logic [ODD_SQ_W-1:0]   odd_sq;
  logic [PROD_W-1:0]     lhs, rhs;
  logic                  fits, out_free;

  assign in_dot = q_data[3*SUM_W:2*SUM_W];
  assign in_na  = q_data[2*SUM_W-1:SUM_W];
  assign in_nb  = q_data[SUM_W-1:0];
  assign in_mag = in_dot[SUM_W] ? SUM_W'(-in_dot) : in_dot[SUM_W-1:0];

  assign cand = m | (MAG_W'(1) << bitn);
  assign odd  = {cand, 1'b0} - ODD_W'(1);
  assign lhs  = PROD_W'(odd_sq) * PROD_W'(p);
  assign rhs  = PROD_W'({d_sq, {FRAC_W{1'b0}}});
  assign fits = (lhs <= rhs);

  assign q_rd     = (state == ST_IDLE) && !q_status.empty;
  assign out_free = !out_valid || pop;
  assign empty    = !out_valid;

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (!q_status.empty) begin
          dot_neg <= in_dot[SUM_W];
          zn      <= (in_na == '0) || (in_nb == '0);
          d_sq    <= SQ_W'(in_mag) * SQ_W'(in_mag);
          p       <= SQ_W'(in_na) * SQ_W'(in_nb);
          m       <= '0;
          bitn    <= BIT_W'(MAG_W - 1);
        end
      end
      ST_SQR: begin
        odd_sq <= ODD_SQ_W'(odd) * ODD_SQ_W'(odd);
      end
      ST_MUL: begin
        if (fits) begin
          m <= cand;
        end
        bitn <= bitn - 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && out_free) begin
      zero_norm <= zn;
      if (zn) begin
        similarity <= '0;
      end else if (dot_neg) begin
        similarity <= -$signed(m);
      end else if (m[MAG_W-1]) begin
        similarity <= Q15_MAX;
      end else begin
        similarity <= $signed(m);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (!q_status.empty) begin
            // zero norms skip the search
            if (in_na == '0 || in_nb == '0) begin
              state <= ST_DONE;
            end else begin
              state <= ST_SQR;
            end
          end
        end
        ST_SQR: begin
          // once bit 15 is set the magnitude is at its cap
          state <= m[MAG_W-1] ? ST_DONE : ST_MUL;
        end
        ST_MUL: begin
          state <= (bitn == '0) ? ST_DONE : ST_SQR;
        end
        ST_DONE: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase

      if (state == ST_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

FILE: sv/ternary_centered_cosine_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ternary_centered_cosine_core
// Centred cosine similarity of two ternary vectors, a pair a cycle unless full.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake        | payload
//  ---------+-----------+------------------+------------------------------
//  trits    | in        | push / full      | trit_a, trit_b, last_pair
//  result   | out       | pop / empty      | similarity, zero_norm
//
//  Pairs are taken one a cycle unless full; the accumulator never stalls itself.
//  Each vector's sums pass through a two-entry queue to the divider, which
//  finds the 16 result bits one by one, finishing a vector before the next.
//  full rises while both queue entries wait; the result register holds
//  until popped; the divider then stalls when done. rst is synchronous.
// ----------------------------------------------------------------------------
module ternary_centered_cosine_core #(
  parameter int unsigned MAX_LENGTH = 240
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic [1:0]         trit_a,
  input  logic [1:0]         trit_b,
  input  logic               last_pair,
  output logic               empty,
  input  logic               pop,
  output logic signed [15:0] similarity,
  output logic               zero_norm
);
  import tccos_pkg::*;

  localparam int unsigned SUM_W = $clog2(MAX_LENGTH + 1);
  localparam int unsigned ENT_W = 3 * SUM_W + 1;

  queue_status_t    q_status;
  logic             q_wr, q_rd, accept;
  logic [ENT_W-1:0] q_wr_data, q_rd_data;

  assign full   = q_status.full;
  assign accept = push && !full;

  tccos_front #(
    .MAX_LENGTH(MAX_LENGTH),
    .SUM_W     (SUM_W)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .trit_a   (trit_a),
    .trit_b   (trit_b),
    .last_pair(last_pair),
    .q_wr     (q_wr),
    .q_data   (q_wr_data)
  );

  tccos_queue #(
    .WIDTH(ENT_W)
  ) u_queue (
    .clk    (clk),
    .rst    (rst),
    .wr     (q_wr),
    .wr_data(q_wr_data),
    .rd     (q_rd),
    .rd_data(q_rd_data),
    .status (q_status)
  );

  tccos_back #(
    .SUM_W     (SUM_W)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_data    (q_rd_data),
    .q_status  (q_status),
    .q_rd      (q_rd),
    .pop       (pop),
    .empty     (empty),
    .similarity(similarity),
    .zero_norm (zero_norm)
  );

endmodule
